@@ design/svf_pkg.sv @@
// shared types and constants of the servo instruction packet framer
package svf_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 5;
    // byte position within a packet, up to 5 + 31 header bytes and params
    localparam int POS_W  = 6;

    localparam logic [BYTE_W-1:0] SYNC_BYTE     = 8'hFF;
    localparam logic [BYTE_W-1:0] WRITE_INSTR   = 8'd3;
    localparam logic [BYTE_W-1:0] PROTECT_RESET = 8'd6;
    localparam logic [BYTE_W-1:0] LEN_EXTRA     = 8'd2;
    localparam logic [CNT_W-1:0]  LEN_TOTAL_ADD = 5'd6;

    localparam logic MODE_HEADER = 1'b0;
    localparam logic MODE_PARAM  = 1'b1;

    // packet byte positions
    localparam logic [POS_W-1:0] POS_SYNC1 = 6'd1;
    localparam logic [POS_W-1:0] POS_ID    = 6'd2;
    localparam logic [POS_W-1:0] POS_LEN   = 6'd3;
    localparam logic [POS_W-1:0] POS_INSTR = 6'd4;
    localparam logic [POS_W-1:0] POS_PARAM = 6'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COLLECT,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture_header;
        logic capture_param;
        logic load_byte;
        logic load_reject;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic param_done;
        logic reject;
        logic last_byte;
    } t_dp_status;

endpackage

@@ design/svf_if.sv @@
// stream and configuration channel interfaces of the packet framer
interface svf_in_if;
    import svf_pkg::*;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [BYTE_W-1:0] servo_id;
    logic [BYTE_W-1:0] instruction;
    logic [CNT_W-1:0]  param_count;
    logic [BYTE_W-1:0] param_byte;

    modport source (output valid, mode, servo_id, instruction, param_count, param_byte,
                    input ready);
    modport sink   (input valid, mode, servo_id, instruction, param_count, param_byte,
                    output ready);
endinterface

interface svf_out_if;
    import svf_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] tx_byte;
    logic              last;
    logic              rejected;
    logic [CNT_W-1:0]  packet_length;

    modport source (output valid, tx_byte, last, rejected, packet_length, input ready);
    modport sink   (input valid, tx_byte, last, rejected, packet_length, output ready);
endinterface

interface svf_cfg_if;
    import svf_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ design/servo_instruction_packet_framer.sv @@
// top level of the servo instruction packet framer
// A header item (id, instruction, count) is followed by count parameter bytes; while
// collecting, one item is taken per cycle and the bytes go into a parameter ram of
// MAX_PARAMS entries (counts above that are clipped). After the last parameter, or
// right at a header with count zero, the packet 0xFF 0xFF id count+2 instruction
// params checksum leaves one byte per cycle from the output register while the
// output is ready, n+6 bytes for n parameters, paced by the byte sequencer and the
// ram's registered read; input is held off during that time. A write instruction
// whose first parameter is below the configured limit gives one flagged result
// instead. Parameter items with no header pending are dropped silently.
// The ram needs no clearing after reset.
module servo_instruction_packet_framer #(
    parameter int MAX_PARAMS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    svf_in_if.sink    i_in,
    svf_out_if.source o_out,
    svf_cfg_if.sink   i_cfg
);
    import svf_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // configuration writes are always taken
    assign i_cfg.ready = 1'b1;

    svf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    svf_datapath #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_data      (i_cfg.data),
        .i_servo_id      (i_in.servo_id),
        .i_instruction   (i_in.instruction),
        .i_param_count   (i_in.param_count),
        .i_param_byte    (i_in.param_byte),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_tx_byte       (o_out.tx_byte),
        .o_last          (o_out.last),
        .o_rejected      (o_out.rejected),
        .o_packet_length (o_out.packet_length)
    );

endmodule

@@ design/svf_ram.sv @@
// generic single write port ram with registered read
module svf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/svf_ctrl.sv @@
// controller state machine of the packet framer
module svf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_mode,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    input  svf_pkg::t_dp_status i_status,
    output svf_pkg::t_dp_cmd    o_cmd
);
    import svf_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_in_fire;
    logic   w_out_free;

    assign o_in_ready = (r_state == ST_IDLE) || (r_state == ST_COLLECT);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE, ST_COLLECT: begin
                if (w_in_fire) begin
                    if (i_in_mode == MODE_HEADER) begin
                        n_state = i_status.count_zero ? ST_EMIT : ST_COLLECT;
                    end else if (r_state == ST_COLLECT && i_status.param_done) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_free && (i_status.reject || i_status.last_byte)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath commands and output valid
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE, ST_COLLECT: begin
                if (w_in_fire) begin
                    if (i_in_mode == MODE_HEADER) begin
                        o_cmd.capture_header = 1'b1;
                    end else if (r_state == ST_COLLECT) begin
                        o_cmd.capture_param = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    o_cmd.load_reject = i_status.reject;
                    o_cmd.load_byte   = !i_status.reject;
                end
            end
            default: o_cmd = '0;
        endcase
        n_out_valid = r_out_valid && !i_out_ready;
        if (o_cmd.load_byte || o_cmd.load_reject) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ design/svf_datapath.sv @@
// header registers, parameter store, byte sequencer and output register
module svf_datapath #(
    parameter int MAX_PARAMS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [svf_pkg::BYTE_W-1:0] i_cfg_data,
    input  logic [svf_pkg::BYTE_W-1:0] i_servo_id,
    input  logic [svf_pkg::BYTE_W-1:0] i_instruction,
    input  logic [svf_pkg::CNT_W-1:0]  i_param_count,
    input  logic [svf_pkg::BYTE_W-1:0] i_param_byte,
    input  svf_pkg::t_dp_cmd           i_cmd,
    output svf_pkg::t_dp_status        o_status,
    output logic [svf_pkg::BYTE_W-1:0] o_tx_byte,
    output logic                       o_last,
    output logic                       o_rejected,
    output logic [svf_pkg::CNT_W-1:0]  o_packet_length
);
    import svf_pkg::*;

    localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam logic [CNT_W+1:0] MaxParams = (CNT_W + 2)'(MAX_PARAMS);

    logic [BYTE_W-1:0] r_limit;
    logic [BYTE_W-1:0] r_id;
    logic [BYTE_W-1:0] r_instr;
    logic [CNT_W-1:0]  r_expected;
    logic [CNT_W-1:0]  r_received;
    logic [BYTE_W-1:0] r_first_param;
    logic [POS_W-1:0]  r_pos;
    logic [BYTE_W-1:0] r_sum;
    logic [BYTE_W-1:0] r_tx_byte;
    logic              r_last;
    logic              r_rejected;
    logic [CNT_W-1:0]  r_length;

    logic [CNT_W-1:0]  w_sat_count;
    logic [CNT_W:0]    w_received_inc;
    logic [POS_W-1:0]  w_last_pos;
    logic [POS_W-1:0]  w_rd_pos;
    logic [BYTE_W-1:0] w_len_byte;
    logic [BYTE_W-1:0] w_byte;
    logic [BYTE_W-1:0] w_rdata;
    logic              w_rd_en;

    // header count saturated to the store depth
    always_comb begin
        if ({2'b00, i_param_count} > MaxParams) begin
            w_sat_count = MaxParams[CNT_W-1:0];
        end else begin
            w_sat_count = i_param_count;
        end
    end

    assign w_received_inc = {1'b0, r_received} + 1'b1;
    assign w_last_pos     = POS_W'(r_expected) + POS_PARAM;
    assign w_len_byte     = BYTE_W'(r_expected) + LEN_EXTRA;
    assign w_rd_pos       = r_pos - POS_INSTR;

    assign o_status.count_zero = (w_sat_count == '0);
    assign o_status.param_done = (w_received_inc >= {1'b0, r_expected});
    assign o_status.reject     = (r_expected != '0) && (r_instr == WRITE_INSTR)
                                 && (r_first_param < r_limit);
    assign o_status.last_byte  = (r_pos == w_last_pos);

    // packet byte at the current position
    always_comb begin
        priority if (r_pos == w_last_pos) begin
            w_byte = ~r_sum;
        end else if (r_pos <= POS_SYNC1) begin
            w_byte = SYNC_BYTE;
        end else if (r_pos == POS_ID) begin
            w_byte = r_id;
        end else if (r_pos == POS_LEN) begin
            w_byte = w_len_byte;
        end else if (r_pos == POS_INSTR) begin
            w_byte = r_instr;
        end else begin
            w_byte = w_rdata;
        end
    end

    // prefetch the parameter needed by the next byte
    assign w_rd_en = i_cmd.load_byte && (r_pos >= POS_INSTR)
                     && (w_rd_pos < POS_W'(r_expected));

    svf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PARAMS),
        .AW    (AW)
    ) u_param_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.capture_param),
        .i_waddr (AW'(r_received)),
        .i_wdata (i_param_byte),
        .i_re    (w_rd_en),
        .i_raddr (AW'(w_rd_pos)),
        .o_rdata (w_rdata)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= PROTECT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // header and collection state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id       <= '0;
            r_instr    <= '0;
            r_expected <= '0;
            r_received <= '0;
        end else if (i_cmd.capture_header) begin
            r_id       <= i_servo_id;
            r_instr    <= i_instruction;
            r_expected <= w_sat_count;
            r_received <= '0;
        end else if (i_cmd.capture_param) begin
            r_received <= w_received_inc[CNT_W-1:0];
        end
    end

    // first parameter kept for the write protection check
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture_param && r_received == '0) begin
            r_first_param <= i_param_byte;
        end
    end

    // byte position and running checksum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
        end else if (i_cmd.capture_header) begin
            r_pos <= '0;
            r_sum <= '0;
        end else if (i_cmd.load_byte) begin
            r_pos <= r_pos + 1'b1;
            if (r_pos >= POS_ID) begin
                r_sum <= r_sum + w_byte;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_reject) begin
            r_tx_byte  <= '0;
            r_last     <= 1'b1;
            r_rejected <= 1'b1;
            r_length   <= '0;
        end else if (i_cmd.load_byte) begin
            r_tx_byte  <= w_byte;
            r_last     <= o_status.last_byte;
            r_rejected <= 1'b0;
            r_length   <= o_status.last_byte ? (r_expected + LEN_TOTAL_ADD) : '0;
        end
    end

    assign o_tx_byte       = r_tx_byte;
    assign o_last          = r_last;
    assign o_rejected      = r_rejected;
    assign o_packet_length = r_length;

endmodule

@@ design/svf_checker.sv @@
// port level checks of the packet framer and their bind
module svf_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [svf_pkg::BYTE_W-1:0] i_tx_byte,
    input logic                       i_last,
    input logic                       i_rejected,
    input logic [svf_pkg::CNT_W-1:0]  i_packet_length
);
    import svf_pkg::*;

    // a refusal is a single final result with zero payload
    a_reject_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_rejected |-> i_last && i_tx_byte == '0 && i_packet_length == '0)
        else $error("refusal result malformed");

    // length only shows on the final byte
    a_length_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> i_packet_length == '0)
        else $error("packet length outside last byte");

    // input is held off while a packet is still being sent
    a_no_input_mid_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last |-> !i_in_ready)
        else $error("input taken during packet emission");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_tx_byte) && $stable(i_last))
        else $error("stalled result changed");

endmodule

bind servo_instruction_packet_framer svf_checker u_svf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_tx_byte       (o_out.tx_byte),
    .i_last          (o_out.last),
    .i_rejected      (o_out.rejected),
    .i_packet_length (o_out.packet_length)
);
